// ----- hdl/limit_order_book_table_assert.svh -----
// assertion macros for the order book table checker
// no dependencies; included by lobt_checker.sv
`ifndef LIMIT_ORDER_BOOK_TABLE_ASSERT_SVH
`define LIMIT_ORDER_BOOK_TABLE_ASSERT_SVH

// clocked property with a disable condition
`define LOBT_ASSERT(label, clk, dis, prop) \
  label: assert property (@(posedge clk) disable iff (dis) prop) \
    else $error("%m: order book assertion failed");

// clocked property that is checked during reset too
`define LOBT_ASSERT_ALWAYS(label, clk, prop) \
  `LOBT_ASSERT(label, clk, 1'b0, prop)

`endif

// ----- hdl/lobt_pkg.sv -----
// shared types and constants for the limit order book table
// no dependencies
package lobt_pkg;

  localparam int SLOTS     = 64;
  localparam int IDX_W     = $clog2(SLOTS);
  localparam int CNT_W     = $clog2(SLOTS + 1);
  localparam int ID_W      = 31;
  localparam int WORD_W    = 32;
  localparam int STAMP_W   = 48;
  localparam int OUT_CNT_W = 7;

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_REMOVE = 2'd1,
    OP_MODIFY = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    STS_DONE      = 2'd0,
    STS_NOT_FOUND = 2'd1,
    STS_FULL      = 2'd2
  } status_t;

  // one table entry
  typedef struct packed {
    logic               used;
    logic               side;
    logic [ID_W-1:0]    ident;
    logic [WORD_W-1:0]  price;
    logic [WORD_W-1:0]  amount;
    logic [STAMP_W-1:0] stamp;
  } slot_t;

endpackage

// ----- hdl/lobt_cmd_if.sv -----
// command channel of the order book table: valid/ready plus one order word
// depends on lobt_pkg
interface lobt_cmd_if import lobt_pkg::*;;
  logic              valid;
  logic              ready;
  op_t               op;
  logic [ID_W-1:0]   order_id;
  logic              is_buy;
  logic [WORD_W-1:0] price;
  logic [WORD_W-1:0] target_price;
  logic [WORD_W-1:0] amount;

  modport source (output valid, op, order_id, is_buy, price, target_price, amount,
                  input ready);
  modport sink   (input valid, op, order_id, is_buy, price, target_price, amount,
                  output ready);
endinterface

// ----- hdl/lobt_rsp_if.sv -----
// result channel of the order book table: valid/ready plus one result word
// depends on lobt_pkg
interface lobt_rsp_if import lobt_pkg::*;;
  logic                 valid;
  logic                 ready;
  status_t              status;
  logic                 book_empty;
  logic [OUT_CNT_W-1:0] level_count;
  logic [OUT_CNT_W-1:0] order_total;

  modport source (output valid, status, book_empty, level_count, order_total,
                  input ready);
  modport sink   (input valid, status, book_empty, level_count, order_total,
                  output ready);
endinterface

// ----- hdl/limit_order_book_table.sv -----
// limit order book table: slot memory, scan sequencer and result register
// depends on lobt_pkg, lobt_cmd_if, lobt_rsp_if
//
// channel  dir  word contents
// -------  ---  --------------------------------------------------------
// cmd      in   op, order_id, is_buy, price, target_price, amount
// rsp      out  status, book_empty, level_count, order_total
//
// add, remove and modify run from accept to result load as one pass over the
//   slot memory (one read port, one slot a cycle, read data registered), then
//   a write-back step and a result step
// clear runs a write pass that frees every slot
// after reset a clearing pass over every slot runs before cmd.ready rises
// a finished word waits in the rsp register; the next command is taken meanwhile
module limit_order_book_table import lobt_pkg::*; (
  input logic        clk,
  input logic        rst,
  lobt_cmd_if.sink   cmd,
  lobt_rsp_if.source rsp
);

  typedef enum logic [4:0] {
    S_SWEEP  = 5'b00001,
    S_IDLE   = 5'b00010,
    S_SCAN   = 5'b00100,
    S_WRITE  = 5'b01000,
    S_FINISH = 5'b10000
  } state_t;

  localparam logic [IDX_W:0]   SCAN_END = (IDX_W+1)'(SLOTS);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

  state_t state;

  // captured command
  op_t               op_r;
  logic [ID_W-1:0]   ident_r;
  logic              side_r;
  logic [WORD_W-1:0] price_r;
  logic [WORD_W-1:0] target_r;
  logic [WORD_W-1:0] amount_r;

  // scan bookkeeping
  logic [IDX_W:0]     scan_idx;
  logic               eval_valid;
  logic [IDX_W-1:0]   eval_idx;
  logic               found;
  logic [IDX_W-1:0]   best_idx;
  logic [STAMP_W-1:0] best_stamp;
  logic               free_found;
  logic [IDX_W-1:0]   free_idx;
  logic [1:0]         cnt_p;      // saturating count of slots at (side, price)
  logic [1:0]         cnt_t;      // same at (side, target)
  logic               sweep_clear;

  // book totals
  logic [CNT_W-1:0]   orders;
  logic [CNT_W-1:0]   levels;
  logic [STAMP_W-1:0] arrival;
  status_t            status_r;

  // slot memory
  slot_t            mem [SLOTS];
  slot_t            rd_data;
  logic             we;
  logic [IDX_W-1:0] wa;
  slot_t            wd;

  // write-back decisions
  status_t          status_next;
  logic [CNT_W-1:0] orders_next;
  logic [CNT_W-1:0] levels_next;
  logic             take_stamp;

  // compare of the slot that comes out of memory this cycle
  logic same_sp;
  logic is_match;
  logic same_st;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_data <= mem[scan_idx[IDX_W-1:0]];
  end

  assign same_sp  = rd_data.used && (rd_data.side == side_r) && (rd_data.price == price_r);
  assign same_st  = rd_data.used && (rd_data.side == side_r) && (rd_data.price == target_r);
  assign is_match = same_sp && (rd_data.ident == ident_r);

  // memory write and totals update; the write pass frees slots, write-back
  // stores the one slot the operation touches
  always_comb begin
    we          = 1'b0;
    wa          = scan_idx[IDX_W-1:0];
    wd          = '0;
    status_next = STS_DONE;
    orders_next = orders;
    levels_next = levels;
    take_stamp  = 1'b0;
    case (state)
      S_SWEEP: begin
        we = 1'b1;
      end
      S_WRITE: begin
        case (op_r)
          OP_ADD: begin
            if (!free_found) begin
              status_next = STS_FULL;
            end else begin
              we          = 1'b1;
              wa          = free_idx;
              wd          = '{used: 1'b1, side: side_r, ident: ident_r, price: price_r,
                              amount: amount_r, stamp: arrival};
              take_stamp  = 1'b1;
              orders_next = orders + 1'b1;
              // a new level opens when nothing rests at this side and price
              if (cnt_p == 2'd0) begin
                levels_next = levels + 1'b1;
              end
            end
          end
          OP_REMOVE: begin
            if (!found) begin
              status_next = STS_NOT_FOUND;
            end else begin
              we          = 1'b1;
              wa          = best_idx;
              orders_next = orders - 1'b1;
              // the level goes away with its last order
              if (cnt_p == 2'd1) begin
                levels_next = levels - 1'b1;
              end
            end
          end
          OP_MODIFY: begin
            if (!found) begin
              status_next = STS_NOT_FOUND;
            end else if (target_r == price_r) begin
              we = 1'b1;
              wa = best_idx;
              wd = '{used: 1'b1, side: side_r, ident: ident_r, price: price_r,
                     amount: amount_r, stamp: best_stamp};
            end else begin
              // reprice: leave the old level, join the new one as newest order
              we         = 1'b1;
              wa         = best_idx;
              wd         = '{used: 1'b1, side: side_r, ident: ident_r, price: target_r,
                             amount: amount_r, stamp: arrival};
              take_stamp = 1'b1;
              levels_next = levels - CNT_W'(cnt_p == 2'd1) + CNT_W'(cnt_t == 2'd0);
            end
          end
          default: begin
            status_next = STS_DONE;
          end
        endcase
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  assign cmd.ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_SWEEP;
      scan_idx    <= '0;
      eval_valid  <= 1'b0;
      sweep_clear <= 1'b0;
      orders      <= '0;
      levels      <= '0;
      arrival     <= '0;
      status_r    <= STS_DONE;
      rsp.valid   <= 1'b0;
    end else begin
      // result register: loads when finishing into a free or draining slot
      if (state == S_FINISH && (!rsp.valid || rsp.ready)) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
      case (state)
        S_SWEEP: begin
          scan_idx <= scan_idx + 1'b1;
          if (scan_idx[IDX_W-1:0] == LAST_IDX) begin
            state <= sweep_clear ? S_FINISH : S_IDLE;
          end
        end
        S_IDLE: begin
          if (cmd.valid) begin
            scan_idx   <= '0;
            eval_valid <= 1'b0;
            if (cmd.op == OP_CLEAR) begin
              // arrival counter is kept across a clear
              state       <= S_SWEEP;
              sweep_clear <= 1'b1;
              orders      <= '0;
              levels      <= '0;
              status_r    <= STS_DONE;
            end else begin
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          // issue one read a cycle; evaluate the slot whose read was issued in the cycle before
          if (scan_idx != SCAN_END) begin
            scan_idx   <= scan_idx + 1'b1;
            eval_valid <= 1'b1;
            eval_idx   <= scan_idx[IDX_W-1:0];
          end else begin
            eval_valid <= 1'b0;
          end
          if (eval_valid && (eval_idx == LAST_IDX)) begin
            state <= S_WRITE;
          end
        end
        S_WRITE: begin
          status_r <= status_next;
          orders   <= orders_next;
          levels   <= levels_next;
          if (take_stamp) begin
            arrival <= arrival + 1'b1;
          end
          state <= S_FINISH;
        end
        S_FINISH: begin
          if (!rsp.valid || rsp.ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // scan results: earliest match, first free slot, level occupancy
  always_ff @(posedge clk) begin
    if (state == S_IDLE) begin
      found      <= 1'b0;
      free_found <= 1'b0;
      cnt_p      <= 2'd0;
      cnt_t      <= 2'd0;
      if (cmd.valid) begin
        op_r     <= cmd.op;
        ident_r  <= cmd.order_id;
        side_r   <= cmd.is_buy;
        price_r  <= cmd.price;
        target_r <= cmd.target_price;
        amount_r <= cmd.amount;
      end
    end else if (state == S_SCAN && eval_valid) begin
      // strict compare keeps the lower slot on equal stamps
      if (is_match && (!found || (rd_data.stamp < best_stamp))) begin
        found      <= 1'b1;
        best_idx   <= eval_idx;
        best_stamp <= rd_data.stamp;
      end
      if (!rd_data.used && !free_found) begin
        free_found <= 1'b1;
        free_idx   <= eval_idx;
      end
      if (same_sp && (cnt_p != 2'd2)) begin
        cnt_p <= cnt_p + 2'd1;
      end
      if (same_st && (cnt_t != 2'd2)) begin
        cnt_t <= cnt_t + 2'd1;
      end
    end
  end

  // result word
  always_ff @(posedge clk) begin
    if (state == S_FINISH && (!rsp.valid || rsp.ready)) begin
      rsp.status      <= status_r;
      rsp.book_empty  <= (orders == '0);
      rsp.level_count <= OUT_CNT_W'(levels);
      rsp.order_total <= OUT_CNT_W'(orders);
    end
  end

endmodule

// ----- hdl/lobt_checker.sv -----
// port-level checks for the limit order book table, bound to the top level
// depends on lobt_pkg and limit_order_book_table_assert.svh
`include "limit_order_book_table_assert.svh"

module lobt_checker import lobt_pkg::*; (
  input logic                 clk,
  input logic                 rst,
  input logic                 cmd_valid,
  input logic                 cmd_ready,
  input logic                 rsp_valid,
  input logic                 rsp_ready,
  input status_t              status,
  input logic                 book_empty,
  input logic [OUT_CNT_W-1:0] level_count,
  input logic [OUT_CNT_W-1:0] order_total
);

  // a stalled result word holds
  `LOBT_ASSERT(a_rsp_hold, clk, rst, rsp_valid && !rsp_ready |=> rsp_valid && $stable(status) && $stable(book_empty) && $stable(level_count) && $stable(order_total))

  // one command at a time: busy right after an accept
  `LOBT_ASSERT(a_busy_after_accept, clk, rst, cmd_valid && cmd_ready |=> !cmd_ready)

  // an empty book has no orders and no levels
  `LOBT_ASSERT(a_empty_counts, clk, rst, rsp_valid && book_empty |-> (order_total == '0) && (level_count == '0))

  // reset starts the clearing pass with nothing to deliver
  `LOBT_ASSERT_ALWAYS(a_reset_quiet, clk, rst |=> !rsp_valid && !cmd_ready)

endmodule

bind limit_order_book_table lobt_checker u_lobt_checker (
  .clk         (clk),
  .rst         (rst),
  .cmd_valid   (cmd.valid),
  .cmd_ready   (cmd.ready),
  .rsp_valid   (rsp.valid),
  .rsp_ready   (rsp.ready),
  .status      (rsp.status),
  .book_empty  (rsp.book_empty),
  .level_count (rsp.level_count),
  .order_total (rsp.order_total)
);
